[design/tqle_pkg.sv]
// Shared types and constants for the Q-learning engine.
`timescale 1ns / 1ps
package tqle_pkg;
	localparam int MaxStates = 64;
	localparam int MaxActions = 16;
	localparam int ReplayDepth = 256;
	localparam int SW = $clog2(MaxStates);
	localparam int AW = $clog2(MaxActions);
	localparam int TW = SW + AW;
	localparam int RW = $clog2(ReplayDepth);

	typedef enum logic [2:0] {
		OP_INIT = 3'd0, OP_UPDATE = 3'd1, OP_STORE = 3'd2, OP_REPLAY = 3'd3, OP_GREEDY = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_BAD = 2'd1, ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_NS = 3'd0, CFG_NA = 3'd1, CFG_LR = 3'd2, CFG_DC = 3'd3, CFG_SEED = 3'd4
	} cfg_idx_t;

	// one replay word: s, a, r, s2
	typedef struct packed {
		logic [SW-1:0] s;
		logic [AW-1:0] a;
		logic signed [31:0] r;
		logic [SW-1:0] s2;
	} trans_t;
endpackage

[design/tabular_q_learning_engine_unit.sv]
// Top level of the tabular Q-learning engine: sequencer, value table, replay ring.
// Replay takes the newest stored words first and skips words with out-of-range indices.
// One operation at a time: busy is high until the result strobe; the receiver cannot
// stall it. The single-port value table and the serial max scan serialise each operation.
// Reset clears the ring pointers and loads register defaults; table undefined until init.
`timescale 1ns / 1ps
module tabular_q_learning_engine_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [2:0] operation,
	input  logic [5:0] state_index,
	input  logic [3:0] action_index,
	input  logic signed [31:0] reward,
	input  logic [5:0] next_state_index,
	input  logic [8:0] batch_len,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] best_action,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import tqle_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'h0001, S_INIT = 13'h0002, S_RFETCH = 13'h0004, S_RWAIT = 13'h0008,
		S_CHK = 13'h0010, S_SCAN = 13'h0020, S_SLAST = 13'h0040, S_MUL1 = 13'h0080,
		S_CUR = 13'h0100, S_MUL2 = 13'h0200, S_WB = 13'h0400, S_DONE = 13'h0800,
		S_GSCAN = 13'h1000
	} fsm_t;

	fsm_t state_q;
	logic [6:0] ns_q;
	logic [4:0] na_q;
	logic [15:0] lr_q, dc_q;
	logic [31:0] seed_q, lcg_q;
	logic [RW-1:0] head_q;
	logic [RW:0] count_q;
	logic [8:0] left_q;
	logic [RW-1:0] ridx_q;
	logic replay_q, greedy_q;
	logic [SW-1:0] s_q, s2_q, is_q;
	logic [AW-1:0] a_q, j_q, best_q;
	logic [AW:0] ia_q;
	logic signed [31:0] r_q, m_q, cur_q;
	logic signed [48:0] prod_q;
	logic signed [33:0] tgt_q;
	logic [1:0] st_q;

	// value table, one port, registered read
	logic signed [31:0] vt_mem [MaxStates*MaxActions];
	logic [TW-1:0] vt_addr;
	logic vt_we;
	logic signed [31:0] vt_wd, vt_rd;
	always_ff @(posedge clk) begin
		if (vt_we) vt_mem[vt_addr] <= vt_wd;
		vt_rd <= vt_mem[vt_addr];
	end

	trans_t rp_mem [ReplayDepth];
	trans_t rp_rd;
	logic rp_we;
	always_ff @(posedge clk) begin
		if (rp_we) rp_mem[head_q] <= trans_t'{state_index, action_index, reward, next_state_index};
		rp_rd <= rp_mem[ridx_q];
	end

	logic [6:0] uns;
	logic [4:0] una;
	assign uns = (ns_q > 7'(MaxStates)) ? 7'(MaxStates) : ns_q;
	assign una = (na_q > 5'(MaxActions)) ? 5'(MaxActions) : na_q;

	logic [31:0] lcg_src, lcg_nx;
	logic signed [44:0] ix;
	// seed the generator at accept, then step it once per table word
	assign lcg_src = (state_q == S_INIT) ? lcg_q : ((seed_q != 0) ? seed_q : 32'd11);
	assign lcg_nx = (lcg_src * 32'd1103515245 + 32'd12345) & 32'h7fffffff;
	assign ix = 45'(signed'({1'b0, lcg_q})) - 45'sh40000000;
	logic signed [44:0] iy;
	assign iy = ix * 45'sd1311 + 45'sh80000000;

	logic signed [33:0] diff;
	assign diff = tgt_q - 34'(cur_q);
	logic signed [49:0] nv;
	assign nv = 50'(cur_q) + 50'(prod_q);

	logic signed [48:0] gamma_prod;
	assign gamma_prod = $signed({1'b0, dc_q}) * m_q;
	logic signed [49:0] alpha_prod;
	assign alpha_prod = $signed({1'b0, lr_q}) * diff;

	logic [AW:0] jn;
	assign jn = {1'b0, j_q} + 1'b1;

	always_comb begin
		vt_we = 1'b0;
		vt_wd = cur_q;
		vt_addr = {s2_q, j_q};
		case (state_q)
			S_INIT: begin
				vt_we = 1'b1;
				vt_addr = {is_q, ia_q[AW-1:0]};
				vt_wd = 32'(iy >>> 32);
			end
			S_MUL1: vt_addr = {s_q, a_q};
			S_WB: begin
				vt_we = 1'b1;
				vt_addr = {s_q, a_q};
				vt_wd = (nv > 50'sh7fffffff) ? 32'sh7fffffff :
					(nv < -50'sh80000000) ? 32'sh80000000 : nv[31:0];
			end
			default: ;
		endcase
	end

	assign rp_we = (state_q == S_IDLE) && start && operation == OP_STORE &&
		count_q < (RW+1)'(ReplayDepth);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ns_q <= 7'd64; na_q <= 5'd16; lr_q <= 16'd6554; dc_q <= 16'd64881;
			seed_q <= 32'd11; head_q <= '0; count_q <= '0;
			done <= 1'b0; status <= ST_OK; best_action <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NS: ns_q <= cfg_data[6:0];
					CFG_NA: na_q <= cfg_data[4:0];
					CFG_LR: lr_q <= cfg_data[15:0];
					CFG_DC: dc_q <= cfg_data[15:0];
					CFG_SEED: seed_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					s_q <= state_index; a_q <= action_index; r_q <= reward;
					s2_q <= next_state_index;
					replay_q <= 1'b0; greedy_q <= 1'b0; best_q <= '0;
					st_q <= ST_OK; state_q <= S_DONE;
					case (operation)
						OP_INIT: if (uns != 0 && una != 0) begin
							lcg_q <= lcg_nx;
							is_q <= '0; ia_q <= '0; state_q <= S_INIT;
						end else st_q <= ST_BAD;
						OP_UPDATE: state_q <= S_CHK;
						OP_STORE: if (rp_we) begin
							head_q <= head_q + 1'b1; count_q <= count_q + 1'b1;
						end else st_q <= ST_FULL;
						OP_REPLAY: if (batch_len == 0) st_q <= ST_BAD;
						else begin
							replay_q <= 1'b1;
							left_q <= (9'(count_q) < batch_len) ? 9'(count_q) : batch_len;
							ridx_q <= head_q - 1'b1;
							state_q <= S_RFETCH;
						end
						OP_GREEDY: if ({1'b0, state_index} < uns && una != 0) begin
							greedy_q <= 1'b1; s2_q <= state_index; j_q <= '0;
							state_q <= S_SCAN;
						end else st_q <= ST_BAD;
						default: st_q <= ST_BAD;
					endcase
				end
				S_INIT: begin
					lcg_q <= lcg_nx;
					if (ia_q + 1'b1 == una) begin
						ia_q <= '0; is_q <= is_q + 1'b1;
						if ({1'b0, is_q} + 7'd1 == uns) begin
							head_q <= '0; count_q <= '0; state_q <= S_DONE;
						end
					end else ia_q <= ia_q + 1'b1;
				end
				S_RFETCH: if (left_q == 0) state_q <= S_DONE;
				else begin
					left_q <= left_q - 1'b1; state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					s_q <= rp_rd.s; a_q <= rp_rd.a; r_q <= rp_rd.r; s2_q <= rp_rd.s2;
					ridx_q <= ridx_q - 1'b1; state_q <= S_CHK;
				end
				S_CHK: begin
					j_q <= '0;
					if ({1'b0, s_q} >= uns || {1'b0, a_q} >= una || {1'b0, s2_q} >= uns) begin
						if (replay_q) state_q <= S_RFETCH;
						else begin
							st_q <= ST_BAD; state_q <= S_DONE;
						end
					end else state_q <= S_SCAN;
				end
				// issue read j, then fold the word that returns
				S_SCAN: begin
					if (j_q != 0 && (vt_rd > m_q)) begin
						m_q <= vt_rd; best_q <= j_q - 1'b1;
					end else if (j_q == 0) m_q <= 32'sh80000000;
					if (jn == (AW+1)'(una)) state_q <= S_SLAST;
					else j_q <= jn[AW-1:0];
				end
				S_SLAST: begin
					if (j_q == 0 || vt_rd > m_q) begin
						m_q <= vt_rd; best_q <= j_q;
					end
					state_q <= greedy_q ? S_DONE : S_MUL1;
				end
				S_MUL1: begin
					prod_q <= gamma_prod;
					state_q <= S_CUR;
				end
				S_CUR: begin
					tgt_q <= 34'(r_q) + 34'(prod_q >>> 16);
					cur_q <= vt_rd; state_q <= S_MUL2;
				end
				S_MUL2: begin
					prod_q <= 49'(alpha_prod >>> 16);
					state_q <= S_WB;
				end
				S_WB: state_q <= replay_q ? S_RFETCH : S_DONE;
				S_DONE: begin
					done <= 1'b1; status <= st_q;
					best_action <= greedy_q ? best_q : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(state_q) == S_DONE)
		else $error("strobe without completion");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= (RW+1)'(ReplayDepth))
		else $error("ring count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> status != 2'd3)
		else $error("bad status code");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && best_action != 0) |-> $past(greedy_q))
		else $error("action on non-greedy result");
endmodule
